// ===== rtl/core/windowed_lnds_tail_table_assert.svh =====
// Assertion macros used by the tail-table back stage (wltt_back).
// Each macro wraps a clocked concurrent assertion with a disable on reset.
`ifndef WINDOWED_LNDS_TAIL_TABLE_ASSERT_SVH
`define WINDOWED_LNDS_TAIL_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold on every rising clock edge outside reset
`define WLTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define WLTT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define WLTT_ASSERT(lbl, clk, rst, prop, msg)
`define WLTT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/core/wltt_pkg.sv =====
`default_nettype none

package wltt_pkg;

   // field widths
   localparam int HEIGHT_W = 32;
   localparam int LENGTH_W = 11;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_HEIGHT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HEIGHT = 1'b1;

   // register reset values
   localparam logic signed [HEIGHT_W-1:0] MIN_HEIGHT_RESET = 32'sh8000_0000;
   localparam logic signed [HEIGHT_W-1:0] MAX_HEIGHT_RESET = 32'sh7FFF_FFFF;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified operation handed from front to back
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic                       insert;
      logic                       last;
   } wltt_op_type;

   typedef struct packed {
      logic        valid;
      wltt_op_type op;
   } wltt_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wltt_qstat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } wltt_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/wltt_if.sv =====
`default_nettype none

// request channel: one sequence element per transaction
interface wltt_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wltt_pkg::HEIGHT_W-1:0] height;
   logic                                carries_value;
   logic                                last;

   modport source (output valid, output height, output carries_value, output last,
                   input ready);
   modport sink   (input valid, input height, input carries_value, input last,
                   output ready);
endinterface

// response channel: one length report per sequence
interface wltt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wltt_pkg::LENGTH_W-1:0] length;
   logic                         overflow;

   modport source (output valid, output length, output overflow, input ready);
   modport sink   (input valid, input length, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wltt_front.sv =====
`default_nettype none

module wltt_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [wltt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wltt_pkg::HEIGHT_W-1:0]        csr_wdata,
   wltt_req_if.sink                                  req_bus,
   input  wire wltt_pkg::wltt_qstat_type             q_stat,
   output wltt_pkg::wltt_push_type                   push
);

   logic signed [wltt_pkg::HEIGHT_W-1:0] min_height_ff;
   logic signed [wltt_pkg::HEIGHT_W-1:0] max_height_ff;
   logic signed [wltt_pkg::HEIGHT_W-1:0] min_height_in;
   logic signed [wltt_pkg::HEIGHT_W-1:0] max_height_in;
   logic                                 req_fire;
   logic                                 in_window;

   // window registers
   always_comb begin
      min_height_in = min_height_ff;
      max_height_in = max_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            wltt_pkg::CSR_MIN_HEIGHT: min_height_in = $signed(csr_wdata);
            wltt_pkg::CSR_MAX_HEIGHT: max_height_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= wltt_pkg::MIN_HEIGHT_RESET;
         max_height_ff <= wltt_pkg::MAX_HEIGHT_RESET;
      end else begin
         min_height_ff <= min_height_in;
         max_height_ff <= max_height_in;
      end
   end

   // accept while the queue has room
   assign req_bus.ready = !q_stat.full;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // classify: kept value, end marker, or nothing to do
   assign in_window = req_bus.carries_value &&
                      (req_bus.height >= min_height_ff) &&
                      (req_bus.height <= max_height_ff);

   always_comb begin
      push.op.height = req_bus.height;
      push.op.insert = in_window;
      push.op.last   = req_bus.last;
      push.valid     = req_fire && (in_window || req_bus.last);
   end

endmodule

`default_nettype wire

// ===== rtl/core/wltt_queue.sv =====
`default_nettype none

module wltt_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wltt_pkg::wltt_push_type  push,
   input  wire logic                     pop,
   output wltt_pkg::wltt_op_type         head,
   output wltt_pkg::wltt_qstat_type      q_stat
);

   wltt_pkg::wltt_op_type            entries_ff [wltt_pkg::QUEUE_DEPTH];
   logic [wltt_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [wltt_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [wltt_pkg::QCNT_W-1:0]      count_ff;
   logic [wltt_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [wltt_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [wltt_pkg::QCNT_W-1:0]      count_in;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + wltt_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + wltt_pkg::QPTR_W'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + wltt_pkg::QCNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - wltt_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.op;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == wltt_pkg::QCNT_W'(wltt_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/wltt_back.sv =====
`default_nettype none

`include "windowed_lnds_tail_table_assert.svh"

module wltt_back #(
   parameter int MAX_LENGTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wltt_pkg::wltt_op_type    head,
   input  wire wltt_pkg::wltt_qstat_type q_stat,
   output logic                          pop,
   wltt_rsp_if.source                    rsp_bus
);

   localparam int CW = $clog2(MAX_LENGTH + 1);
   localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   // tail memory
   logic signed [wltt_pkg::HEIGHT_W-1:0] tails_mem [MAX_LENGTH];
   logic signed [wltt_pkg::HEIGHT_W-1:0] rd_data_ff;
   logic [AW-1:0]                        rd_addr;
   logic [AW-1:0]                        wr_addr;
   logic                                 wr_en;

   // control state
   wltt_pkg::wltt_state_type state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload registers
   wltt_pkg::wltt_op_type         op_ff, op_in;
   logic [CW-1:0]                 lo_ff, lo_in;
   logic [CW-1:0]                 hi_ff, hi_in;
   logic [AW-1:0]                 mid_ff, mid_in;
   logic [wltt_pkg::LENGTH_W-1:0] rsp_len_ff, rsp_len_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   // search step
   logic [CW-1:0]                 lo_s;
   logic [CW-1:0]                 hi_s;
   logic [CW:0]                   sum_s;
   logic [AW-1:0]                 mid_s;
   logic                          search_done;
   logic [CW+wltt_pkg::LENGTH_W-1:0] count_ext;
   logic                          emit_fire;

   // one halving of [lo, hi) from the tail read last cycle
   always_comb begin
      lo_s = lo_ff;
      hi_s = hi_ff;
      if (pend_ff) begin
         if (rd_data_ff > $signed(op_ff.height)) begin
            hi_s = CW'(mid_ff);
         end else begin
            lo_s = CW'(mid_ff) + CW'(1);
         end
      end
      sum_s       = {1'b0, lo_s} + {1'b0, hi_s};
      mid_s       = sum_s[AW:1];
      search_done = (lo_s >= hi_s);
   end

   assign count_ext = {{wltt_pkg::LENGTH_W{1'b0}}, count_ff};
   assign emit_fire = (state_ff == wltt_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_addr      = mid_ff;

      unique case (state_ff)
         wltt_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               pop     = 1'b1;
               op_in   = head;
               lo_in   = '0;
               hi_in   = count_ff;
               pend_in = 1'b0;
               state_in = head.insert ? wltt_pkg::ST_SEARCH : wltt_pkg::ST_EMIT;
            end
         end

         wltt_pkg::ST_SEARCH: begin
            if (!search_done) begin
               lo_in   = lo_s;
               hi_in   = hi_s;
               mid_in  = mid_s;
               rd_addr = mid_s;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               // replace the first greater tail, append, or flag a full table
               if (lo_s < count_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = lo_s[AW-1:0];
               end else if (count_ff < CW'(MAX_LENGTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = op_ff.last ? wltt_pkg::ST_EMIT : wltt_pkg::ST_IDLE;
            end
         end

         wltt_pkg::ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = count_ext[wltt_pkg::LENGTH_W-1:0];
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = wltt_pkg::ST_IDLE;
            end
         end

         default: state_in = wltt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wltt_pkg::ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // tail memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tails_mem[wr_addr] <= $signed(op_ff.height);
      end
      rd_data_ff <= tails_mem[rd_addr];
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.length   = rsp_len_ff;
   assign rsp_bus.overflow = rsp_ovf_ff;

   // checks
   `WLTT_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_LENGTH), "tail count past table size")
   `WLTT_ASSERT(a_search_window, clock, reset, (state_ff == wltt_pkg::ST_SEARCH) |-> (lo_ff <= hi_ff && hi_ff <= count_ff), "search window outside table")
   `WLTT_ASSERT(a_emit_clears, clock, reset, emit_fire |=> (count_ff == '0 && !ovf_ff && rsp_valid_ff), "report did not clear the sequence")
   `WLTT_NEVER(a_pend_state, clock, reset, pend_ff && state_ff != wltt_pkg::ST_SEARCH, "tail read pending outside search")

endmodule

`default_nettype wire

// ===== rtl/core/windowed_lnds_tail_table.sv =====
// Longest non-decreasing subsequence length over a windowed value stream.
// req_bus carries one element per transaction (height, carries_value, last).
// Elements with carries_value set and height inside [min_height, max_height]
// update a tail table; a transaction with last set yields one rsp_bus
// transaction with the table length and the overflow flag, then clears both.
// The window registers are written through csr_we / csr_index / csr_wdata.
// A front stage classifies each transaction into a two-entry queue; the back
// stage runs a binary search over the tail memory, one compare per cycle.
// Each inserted element runs the search loop on the memory read port, whose
// number of steps grows with the table length; the emit state follows the
// search when the same transaction also ends the sequence.
// An end marker without a value goes from idle straight to emit; its result
// is registered in the output register when the emit state fires.
// Reset restores the window to the full signed range and empties the table;
// no memory clear is needed since only written entries are ever searched.
// A stalled receiver holds the result in the output register; the queue keeps
// accepting until it fills, then req_bus.ready drops.
`default_nettype none

module windowed_lnds_tail_table #(
   parameter int MAX_LENGTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [wltt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wltt_pkg::HEIGHT_W-1:0]    csr_wdata,
   wltt_req_if.sink                              req_bus,
   wltt_rsp_if.source                            rsp_bus
);

   wltt_pkg::wltt_push_type  push;
   wltt_pkg::wltt_qstat_type q_stat;
   wltt_pkg::wltt_op_type    head;
   logic                     pop;

   wltt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .q_stat    (q_stat),
      .push      (push)
   );

   wltt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   wltt_back #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
